>>> rtl/btpc_pkg.sv
// Shared types and constants for the barometric temperature/pressure compensation block.
// No dependencies; btpc_front, btpc_back and the top level use it by scoped names.
package btpc_pkg;

  localparam int unsigned RawW    = 20;
  localparam int unsigned TempW   = 16;
  localparam int unsigned PressW  = 20;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 32;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegT1   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegT2   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegT3   = 4'd2;
  localparam logic [CfgIdxW-1:0] RegP1   = 4'd3;
  localparam logic [CfgIdxW-1:0] RegP23  = 4'd4;
  localparam logic [CfgIdxW-1:0] RegP45  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegP67  = 4'd6;
  localparam logic [CfgIdxW-1:0] RegP89  = 4'd7;

  localparam logic [63:0] TFineOffset = 64'd128000;
  localparam logic [63:0] PressScale  = 64'd3125;
  localparam logic [63:0] PressFull   = 64'd1048576;
  localparam logic [63:0] PressMax    = 64'd1048575;
  localparam logic [63:0] PressBias   = 64'd1 << 47;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } item_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [31:0] p23;
    logic [31:0] p45;
    logic [31:0] p67;
    logic [31:0] p89;
  } coeff_t;

  // handshake between the queue and the sequencer
  typedef struct packed {
    logic  avail;
    item_t item;
  } queue_head_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LAUNCH,
    BK_WAIT,
    BK_DIV_LAUNCH,
    BK_DIV_WAIT,
    BK_OUT
  } bk_state_e;

  // sequencer steps, one per multiply (and one for the divide)
  typedef enum logic [3:0] {
    ST_TA,
    ST_TDD,
    ST_TB,
    ST_V1SQ,
    ST_V2A,
    ST_V2B,
    ST_V1A,
    ST_V1B,
    ST_V1C,
    ST_NUM,
    ST_DIV,
    ST_W1A,
    ST_W1B,
    ST_W2
  } step_e;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] v);
    sx32 = {{32{v[31]}}, v};
  endfunction

endpackage

>>> rtl/btpc_front.sv
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on btpc_pkg.
module btpc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  btpc_pkg::item_t      item_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output btpc_pkg::queue_head_t head_o
);

  btpc_pkg::item_t slot_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o       = count_q[1];
  assign head_o.avail = (count_q != 2'd0);
  assign head_o.item  = slot_q[rd_ptr_q];

endmodule

>>> rtl/btpc_mul.sv
// Shared 64x64 multiplier keeping the low 64 bits, built from one 32x32 multiplier
// used in turn for each partial. Depends on nothing.
module btpc_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic [63:0] a_q, b_q, pr_q, acc_q;
  logic [1:0]  cnt_q;
  logic        run_q, done_q;
  logic [31:0] op_a, op_b;

  // partials: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
  assign op_a = (cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
  assign op_b = (cnt_q == 2'd1) ? b_q[63:32] : b_q[31:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (run_q) begin
      pr_q <= op_a * op_b;
      case (cnt_q)
        2'd1:    acc_q <= pr_q;
        2'd2:    acc_q <= acc_q + {pr_q[31:0], 32'd0};
        2'd3:    acc_q <= acc_q + {pr_q[31:0], 32'd0};
        default: acc_q <= acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= 2'd0;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      cnt_q  <= cnt_q + 2'd1;
      run_q  <= (cnt_q != 2'd3);
      done_q <= (cnt_q == 2'd3);
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> rtl/btpc_div.sv
// Signed 64-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on nothing.
module btpc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [63:0] rem_q, quo_q, den_q, res_q;
  logic        neg_q;
  logic [5:0]  cnt_q;
  logic        run_q, fin_q, done_q;
  logic [64:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, quo_q[63]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[63] ^ den_i[63];
      rem_q <= 64'd0;
      quo_q <= num_i[63] ? (64'd0 - num_i) : num_i;
      den_q <= den_i[63] ? (64'd0 - den_i) : den_i;
    end else if (run_q) begin
      rem_q <= ge ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
      quo_q <= {quo_q[62:0], ge};
    end
    if (fin_q) begin
      res_q <= neg_q ? (64'd0 - quo_q) : quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 6'd0;
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin_q;
      fin_q  <= run_q && (cnt_q == 6'd63);
      if (start_i) begin
        cnt_q <= 6'd0;
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        run_q <= (cnt_q != 6'd63);
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

>>> rtl/btpc_back.sv
// Back end: sequences the compensation polynomials over the shared multiplier and
// divider and drives the registered result. Depends on btpc_pkg, btpc_mul, btpc_div.
module btpc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  btpc_pkg::coeff_t        coeff_i,
  input  btpc_pkg::queue_head_t   head_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic signed [15:0]      temperature_centideg_o,
  output logic [19:0]             pressure_pascal_o,
  output logic                    divide_fault_o
);

  btpc_pkg::bk_state_e state_q, state_d;
  btpc_pkg::step_e     step_q;

  logic [19:0] rt_q, rp_q;
  logic [31:0] a_q, e_q, tf_q;
  logic [63:0] v1_q, s_q, v2_q, w_q, num_q, q_q;
  logic        fault_q;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, m, div_q;
  logic [63:0] ps, v1_new;
  logic [31:0] x32, d32, fine;

  logic        done_q, fault_out_q;
  logic [15:0] temp_q;
  logic [19:0] press_q;

  btpc_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(m)
  );

  btpc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_q), .den_i(v1_q),
    .done_o(div_done), .quo_o(div_q)
  );

  assign x32    = {15'd0, rt_q[19:3]} - {15'd0, coeff_i.t1, 1'b0};
  assign d32    = {16'd0, rt_q[19:4]} - {16'd0, coeff_i.t1};
  assign ps     = $signed(q_q) >>> 13;
  assign fine   = a_q + 32'($signed(m[31:0]) >>> 14);
  assign v1_new = $signed(m) >>> 33;

  // operand select for the step in flight
  always_comb begin
    mul_a = 64'd0;
    mul_b = 64'd0;
    case (step_q)
      btpc_pkg::ST_TA:   begin mul_a = btpc_pkg::sx32(x32); mul_b = btpc_pkg::sx16(coeff_i.t2); end
      btpc_pkg::ST_TDD:  begin mul_a = btpc_pkg::sx32(d32); mul_b = btpc_pkg::sx32(d32); end
      btpc_pkg::ST_TB:   begin mul_a = btpc_pkg::sx32(e_q); mul_b = btpc_pkg::sx16(coeff_i.t3); end
      btpc_pkg::ST_V1SQ: begin mul_a = v1_q; mul_b = v1_q; end
      btpc_pkg::ST_V2A:  begin mul_a = s_q;  mul_b = btpc_pkg::sx16(coeff_i.p67[15:0]); end
      btpc_pkg::ST_V2B:  begin mul_a = v1_q; mul_b = btpc_pkg::sx16(coeff_i.p45[31:16]); end
      btpc_pkg::ST_V1A:  begin mul_a = s_q;  mul_b = btpc_pkg::sx16(coeff_i.p23[31:16]); end
      btpc_pkg::ST_V1B:  begin mul_a = v1_q; mul_b = btpc_pkg::sx16(coeff_i.p23[15:0]); end
      btpc_pkg::ST_V1C:  begin
        mul_a = btpc_pkg::PressBias + w_q;
        mul_b = {48'd0, coeff_i.p1};
      end
      btpc_pkg::ST_NUM:  begin
        mul_a = {33'(btpc_pkg::PressFull - {44'd0, rp_q}), 31'd0} - v2_q;
        mul_b = btpc_pkg::PressScale;
      end
      btpc_pkg::ST_W1A:  begin mul_a = btpc_pkg::sx16(coeff_i.p89[31:16]); mul_b = ps; end
      btpc_pkg::ST_W1B:  begin mul_a = w_q;  mul_b = ps; end
      btpc_pkg::ST_W2:   begin mul_a = btpc_pkg::sx16(coeff_i.p89[15:0]); mul_b = q_q; end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      btpc_pkg::BK_IDLE:       if (head_i.avail) state_d = btpc_pkg::BK_LAUNCH;
      btpc_pkg::BK_LAUNCH:     state_d = btpc_pkg::BK_WAIT;
      btpc_pkg::BK_WAIT: begin
        if (mul_done) begin
          if (step_q == btpc_pkg::ST_V1C && v1_new == 64'd0) state_d = btpc_pkg::BK_OUT;
          else if (step_q == btpc_pkg::ST_NUM) state_d = btpc_pkg::BK_DIV_LAUNCH;
          else if (step_q == btpc_pkg::ST_W2) state_d = btpc_pkg::BK_OUT;
          else state_d = btpc_pkg::BK_LAUNCH;
        end
      end
      btpc_pkg::BK_DIV_LAUNCH: state_d = btpc_pkg::BK_DIV_WAIT;
      btpc_pkg::BK_DIV_WAIT:   if (div_done) state_d = btpc_pkg::BK_LAUNCH;
      btpc_pkg::BK_OUT:        state_d = btpc_pkg::BK_IDLE;
      default:                 state_d = btpc_pkg::BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o     = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      btpc_pkg::BK_IDLE:       pop_o = head_i.avail;
      btpc_pkg::BK_LAUNCH:     mul_start = 1'b1;
      btpc_pkg::BK_DIV_LAUNCH: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btpc_pkg::BK_IDLE;
      step_q  <= btpc_pkg::ST_TA;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == btpc_pkg::BK_OUT);
      if (state_q == btpc_pkg::BK_IDLE) begin
        step_q <= btpc_pkg::ST_TA;
      end else if (state_q == btpc_pkg::BK_WAIT && mul_done) begin
        step_q <= btpc_pkg::step_e'(step_q + 4'd1);
      end else if (state_q == btpc_pkg::BK_DIV_WAIT && div_done) begin
        step_q <= btpc_pkg::ST_W1A;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == btpc_pkg::BK_IDLE && head_i.avail) begin
      rt_q    <= head_i.item.raw_temperature;
      rp_q    <= head_i.item.raw_pressure;
      fault_q <= 1'b0;
    end
    if (state_q == btpc_pkg::BK_DIV_WAIT && div_done) begin
      q_q <= div_q;
    end
    if (state_q == btpc_pkg::BK_WAIT && mul_done) begin
      case (step_q)
        btpc_pkg::ST_TA:   a_q <= 32'($signed(m[31:0]) >>> 11);
        btpc_pkg::ST_TDD:  e_q <= 32'($signed(m[31:0]) >>> 12);
        btpc_pkg::ST_TB: begin
          tf_q <= fine;
          v1_q <= btpc_pkg::sx32(fine) - btpc_pkg::TFineOffset;
        end
        btpc_pkg::ST_V1SQ: s_q  <= m;
        btpc_pkg::ST_V2A:  v2_q <= m;
        btpc_pkg::ST_V2B:  v2_q <= v2_q + {m[46:0], 17'd0}
                                   + {{13{coeff_i.p45[15]}}, coeff_i.p45[15:0], 35'd0};
        btpc_pkg::ST_V1A:  w_q  <= $signed(m) >>> 8;
        btpc_pkg::ST_V1B:  w_q  <= w_q + {m[51:0], 12'd0};
        btpc_pkg::ST_V1C: begin
          v1_q    <= v1_new;
          fault_q <= (v1_new == 64'd0);
        end
        btpc_pkg::ST_NUM:  num_q <= m;
        btpc_pkg::ST_W1A:  w_q  <= m;
        btpc_pkg::ST_W1B:  w_q  <= $signed(m) >>> 25;
        btpc_pkg::ST_W2:   v2_q <= $signed(m) >>> 19;
        default: ;
      endcase
    end
  end

  // final scaling and saturation
  logic signed [35:0] tc_full;
  logic signed [27:0] tc;
  logic [63:0]        p_sum, p_mid, p_fin;

  assign tc_full = (36'(signed'(tf_q)) <<< 2) + 36'(signed'(tf_q)) + 36'sd128;
  assign tc      = 28'(tc_full >>> 8);
  assign p_sum   = q_q + w_q + v2_q;
  assign p_mid   = 64'($signed(p_sum) >>> 8)
                   + {{44{coeff_i.p67[31]}}, coeff_i.p67[31:16], 4'd0};
  assign p_fin   = $signed(p_mid) >>> 8;

  always_ff @(posedge clk_i) begin
    if (state_q == btpc_pkg::BK_OUT) begin
      if (tc > 28'sd32767) temp_q <= 16'h7fff;
      else if (tc < -28'sd32768) temp_q <= 16'h8000;
      else temp_q <= tc[15:0];
      if (fault_q || p_fin[63]) press_q <= 20'd0;
      else if (p_fin > btpc_pkg::PressMax) press_q <= 20'hfffff;
      else press_q <= p_fin[19:0];
      fault_out_q <= fault_q;
    end
  end

  assign done_o                 = done_q;
  assign temperature_centideg_o = temp_q;
  assign pressure_pascal_o      = press_q;
  assign divide_fault_o         = fault_out_q;

endmodule

>>> rtl/baro_temp_press_compensation.sv
// Top level of the barometric temperature/pressure compensation block.
// Depends on btpc_pkg, btpc_front, btpc_back (and through it btpc_mul, btpc_div).

// A request (start high while busy is low) carries one raw temperature and pressure
// pair; each gives exactly one result, shown for one cycle with done_o high, and the
// receiver cannot stall it. Requests queue two deep ahead of the sequencer, so busy
// rises only when two are waiting. One item runs thirteen 64-bit multiplies on the
// shared 32x32 multiplier and one pass through the one-bit-per-cycle divider, between
// taking the request and registering the result; a zero divisor skips the divide
// and the last four multiplies. Write calibration only while no request is in
// flight; writes to indexes above seven are dropped.
module baro_temp_press_compensation (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [19:0]         raw_temperature_i,
  input  logic [19:0]         raw_pressure_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                done_o,
  output logic signed [15:0]  temperature_centideg_o,
  output logic [19:0]         pressure_pascal_o,
  output logic                divide_fault_o
);

  btpc_pkg::coeff_t      coeff_q;
  btpc_pkg::item_t       item;
  btpc_pkg::queue_head_t head;
  logic                  pop, full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        btpc_pkg::RegT1:  coeff_q.t1  <= cfg_data_i[15:0];
        btpc_pkg::RegT2:  coeff_q.t2  <= cfg_data_i[15:0];
        btpc_pkg::RegT3:  coeff_q.t3  <= cfg_data_i[15:0];
        btpc_pkg::RegP1:  coeff_q.p1  <= cfg_data_i[15:0];
        btpc_pkg::RegP23: coeff_q.p23 <= cfg_data_i;
        btpc_pkg::RegP45: coeff_q.p45 <= cfg_data_i;
        btpc_pkg::RegP67: coeff_q.p67 <= cfg_data_i;
        btpc_pkg::RegP89: coeff_q.p89 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign item.raw_temperature = raw_temperature_i;
  assign item.raw_pressure    = raw_pressure_i;
  assign busy                 = full;

  btpc_front u_front (
    .clk_i, .rst_ni,
    .push_i(start && !full),
    .item_i(item),
    .pop_i(pop),
    .full_o(full),
    .head_o(head)
  );

  btpc_back u_back (
    .clk_i, .rst_ni,
    .coeff_i(coeff_q),
    .head_i(head),
    .pop_o(pop),
    .done_o,
    .temperature_centideg_o,
    .pressure_pascal_o,
    .divide_fault_o
  );

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held longer than one cycle");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && divide_fault_o |-> pressure_pascal_o == 20'd0)
    else $error("pressure not zero on divide fault");

  a_pop_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.avail) else $error("pop from empty queue");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for baro_temp_press_compensation.
// Needs btpc_pkg and the RTL; it computes the expected temperature and pressure of each request.

module tb_top;

  typedef struct {
    logic [btpc_pkg::RawW-1:0] rt;
    logic [btpc_pkg::RawW-1:0] rp;
    int                        gap;
    bit                        hold;
  } reading_t;

  typedef struct {
    logic [btpc_pkg::TempW-1:0]  temp;
    logic [btpc_pkg::PressW-1:0] press;
    logic                        fault;
  } comp_t;

  localparam logic [btpc_pkg::CfgIdxW-1:0] RegUnused = 4'd11;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [19:0]         raw_temperature_i = '0;
  logic [19:0]         raw_pressure_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [3:0]          cfg_index_i = '0;
  logic [31:0]         cfg_data_i = '0;
  logic                done_o;
  logic signed [15:0]  temperature_centideg_o;
  logic [19:0]         pressure_pascal_o;
  logic                divide_fault_o;

  baro_temp_press_compensation uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [31:0] calib [8];
  reading_t    reading_q [$];
  comp_t       comp_q [$];
  int          errors = 0;
  int          n_reads = 0;
  int          n_faults = 0;
  int          n_phases = 0;
  bit          quiet = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("ERROR t=%0t %s got %0d want %0d", $time, what, got, want);
  endtask

  function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
    logic signed [63:0] s;
    s = x;
    s = s >>> n;
    return s;
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    logic signed [31:0] s;
    s = x;
    s = s >>> n;
    return s;
  endfunction

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic comp_t compensate(input logic [btpc_pkg::RawW-1:0] rt,
                                       input logic [btpc_pkg::RawW-1:0] rp);
    logic [31:0] t1, t2, t3, a, d, b, fine, x;
    logic [63:0] tf, tc, v1, v2, p, ps, w1, w2, num, ua, ub, q;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] sc;
    comp_t r;
    t1 = {16'd0, calib[btpc_pkg::RegT1][15:0]};
    t2 = {{16{calib[btpc_pkg::RegT2][15]}}, calib[btpc_pkg::RegT2][15:0]};
    t3 = {{16{calib[btpc_pkg::RegT3][15]}}, calib[btpc_pkg::RegT3][15:0]};
    x = (({12'd0, rt}) >> 3) - (t1 << 1);
    a = sra32(x * t2, 11);
    d = (({12'd0, rt}) >> 4) - t1;
    x = sra32(d * d, 12);
    b = sra32(x * t3, 14);
    fine = a + b;
    tf = {{32{fine[31]}}, fine};
    tc = sra64(tf * 64'd5 + 64'd128, 8);
    sc = tc;
    if (sc < -32768) r.temp = 16'h8000;
    else if (sc > 32767) r.temp = 16'h7fff;
    else r.temp = tc[15:0];

    p1 = {48'd0, calib[btpc_pkg::RegP1][15:0]};
    p2 = sext16(calib[btpc_pkg::RegP23][15:0]);
    p3 = sext16(calib[btpc_pkg::RegP23][31:16]);
    p4 = sext16(calib[btpc_pkg::RegP45][15:0]);
    p5 = sext16(calib[btpc_pkg::RegP45][31:16]);
    p6 = sext16(calib[btpc_pkg::RegP67][15:0]);
    p7 = sext16(calib[btpc_pkg::RegP67][31:16]);
    p8 = sext16(calib[btpc_pkg::RegP89][15:0]);
    p9 = sext16(calib[btpc_pkg::RegP89][31:16]);
    v1 = tf - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 64'd0) begin
      r.press = '0;
      r.fault = 1'b1;
    end else begin
      p = 64'd1048576 - {44'd0, rp};
      num = ((p << 31) - v2) * 64'd3125;
      // signed divide toward zero on magnitudes
      ua = num[63] ? (64'd0 - num) : num;
      ub = v1[63] ? (64'd0 - v1) : v1;
      q = ua / ub;
      p = (num[63] != v1[63]) ? (64'd0 - q) : q;
      ps = sra64(p, 13);
      w1 = sra64(p9 * ps * ps, 25);
      w2 = sra64(p8 * p, 19);
      p = sra64(p + w1 + w2, 8) + (p7 << 4);
      p = sra64(p, 8);
      if (p[63]) r.press = '0;
      else if (p > 64'd1048575) r.press = 20'hfffff;
      else r.press = p[19:0];
      r.fault = 1'b0;
    end
    return r;
  endfunction

  // driver: present the head of the queue, pop it when the request is taken
  logic    taken;
  reading_t head;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        comp_q.push_back(compensate(raw_temperature_i, raw_pressure_i));
        void'(reading_q.pop_front());
        n_reads++;
      end
      if (start && !taken) begin
        // hold the request
      end else if (reading_q.size() == 0) begin
        start <= 1'b0;
      end else if (reading_q[0].gap > 0) begin
        head = reading_q[0];
        head.gap--;
        reading_q[0] = head;
        start <= 1'b0;
      end else if (reading_q[0].hold && comp_q.size() != 0) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        raw_temperature_i <= reading_q[0].rt;
        raw_pressure_i <= reading_q[0].rp;
      end
    end
  end

  // monitor
  comp_t want;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (comp_q.size() == 0) begin
        report("result with nothing pending", pressure_pascal_o, 0);
      end else begin
        want = comp_q.pop_front();
        if (want.fault) n_faults++;
        if (temperature_centideg_o !== want.temp)
          report("temperature", temperature_centideg_o, $signed(want.temp));
        if (pressure_pascal_o !== want.press)
          report("pressure", pressure_pascal_o, want.press);
        if (divide_fault_o !== want.fault)
          report("divide fault", divide_fault_o, want.fault);
      end
    end
  end

  task automatic cfg_write(input logic [btpc_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx <= btpc_pkg::RegP89) begin
      if (idx <= btpc_pkg::RegP1) calib[idx] = {16'd0, data[15:0]};
      else calib[idx] = data;
    end
  endtask

  task automatic write_calib(input logic [31:0] c [8]);
    cfg_write(RegUnused, $urandom());
    for (int i = 0; i < 8; i++) cfg_write(i[btpc_pkg::CfgIdxW-1:0], c[i]);
    n_phases++;
  endtask

  task automatic push_reading(input logic [19:0] rt, input logic [19:0] rp);
    reading_t r;
    r.rt = rt;
    r.rp = rp;
    r.gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 3);
    r.hold = !quiet && ($urandom_range(0, 60) == 0);
    reading_q.push_back(r);
  endtask

  task automatic drain();
    while (reading_q.size() != 0 || comp_q.size() != 0 || start) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  logic [31:0] typ [8];
  logic [31:0] c [8];
  initial begin
    for (int i = 0; i < 8; i++) calib[i] = '0;
    typ[0] = 27504;
    typ[1] = 26435;
    typ[2] = 16'hfc18;
    typ[3] = 36477;
    typ[4] = {16'd3024, 16'hd643};
    typ[5] = {16'd140, 16'd2855};
    typ[6] = {16'd15500, 16'hfff9};
    typ[7] = {16'd6000, 16'hc6f8};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset calibration: divisor is zero
    push_reading(20'h00000, 20'h00000);
    push_reading(20'hfffff, 20'hfffff);
    push_reading(20'h7eed0, 20'h655ac);
    drain();

    write_calib(typ);
    push_reading(20'd519888, 20'd415148);
    push_reading(20'h00000, 20'h00000);
    push_reading(20'hfffff, 20'hfffff);
    push_reading(20'h00000, 20'hfffff);
    push_reading(20'hfffff, 20'h00000);
    push_reading(20'd400000, 20'd300000);
    push_reading(20'd600000, 20'd500000);
    drain();

    for (int i = 0; i < 8; i++) c[i] = 32'h7fff7fff;
    c[0] = 32'hffff;
    c[3] = 32'hffff;
    write_calib(c);
    push_reading(20'hfffff, 20'h00000);
    push_reading(20'h00000, 20'hfffff);
    push_reading(20'h80000, 20'h80000);
    drain();

    for (int i = 0; i < 8; i++) c[i] = 32'h80008000;
    c[0] = 32'h0;
    c[3] = 32'h1;
    write_calib(c);
    push_reading(20'hfffff, 20'hfffff);
    push_reading(20'h00000, 20'h00000);
    push_reading(20'h12345, 20'hedcba);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph == 9);
      for (int i = 0; i < 8; i++) begin
        if (ph % 3 == 2) c[i] = $urandom();
        else c[i] = typ[i] + $urandom_range(0, 64) - 32;
      end
      if (ph == 4) c[3] = 32'h0;
      write_calib(c);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 3) == 0)
          push_reading(20'($urandom()), 20'($urandom()));
        else
          push_reading(20'(20'd519888 + $urandom_range(0, 200000) - 100000),
                       20'(20'd415148 + $urandom_range(0, 200000) - 100000));
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    $display("covered %0d readings over %0d calibration sets, %0d with zero divisor",
             n_reads, n_phases, n_faults);
    if (errors == 0 && comp_q.size() == 0) begin
      $display("baro_temp_press_compensation: match");
    end else begin
      $display("baro_temp_press_compensation: mismatch");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("timeout with %0d results pending", comp_q.size());
    $display("baro_temp_press_compensation: mismatch");
    $finish;
  end

endmodule

>>> baro_temp_press_compensation.f
rtl/btpc_pkg.sv
rtl/btpc_front.sv
rtl/btpc_mul.sv
rtl/btpc_div.sv
rtl/btpc_back.sv
rtl/baro_temp_press_compensation.sv
test/tb_top.sv
